### sv/top_k_max_sum_core_defines.svh
// Assertion macros for the top-k maximum-sum core.
// Used by top_k_max_sum_core; expands to nothing when SYNTHESIS is defined.
`ifndef TOP_K_MAX_SUM_CORE_DEFINES_SVH
`define TOP_K_MAX_SUM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define TKMS_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("top_k_max_sum_core: same-cycle check failed");
`define TKMS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("top_k_max_sum_core: next-cycle check failed");
`else
`define TKMS_ASSERT_SAME(lbl, ante, cons)
`define TKMS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### sv/tkms_pkg.sv
// Shared widths and types for the top-k maximum-sum core.
// No dependencies; imported by every module of the core.
package tkms_pkg;

  localparam int VAL_W = 32;
  localparam int SUM_W = 36;
  localparam int K_W   = 5;

  // What one cell hands to the next one down the chain.
  typedef struct packed {
    logic                    stays;
    logic signed [VAL_W-1:0] entry;
  } tkms_link_t;

endpackage

### sv/tkms_cell.sv
// One cell of the sorted insertion chain: holds one entry of the descending store.
// Depends on tkms_pkg.
module tkms_cell (
  input  logic                             clk,
  input  logic                             accept,
  input  logic signed [tkms_pkg::VAL_W-1:0] value,
  input  logic                             occupied,
  input  tkms_pkg::tkms_link_t             prev,
  output tkms_pkg::tkms_link_t             link,
  output logic signed [tkms_pkg::VAL_W-1:0] entry
);
  import tkms_pkg::*;

  logic signed [VAL_W-1:0] entry_r;
  logic signed [VAL_W-1:0] entry_nxt;
  logic                    stays;

  // Equal values keep their place, so a new element lands after them.
  assign stays = occupied && (entry_r >= value);

  always_comb begin
    entry_nxt = entry_r;
    if (!stays) begin
      entry_nxt = prev.stays ? value : prev.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      entry_r <= entry_nxt;
    end
  end

  assign link.stays = stays;
  assign link.entry = entry_r;
  assign entry      = entry_r;

endmodule

### sv/tkms_sum_tree.sv
// Registered adder tree with backpressure that sums the selected lanes of a snapshot.
// Depends on tkms_pkg.
module tkms_sum_tree #(
  parameter int LANES  = 16,
  parameter int LEVELS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_too_few,
  input  logic signed [tkms_pkg::SUM_W-1:0] lane_val [LANES],
  output logic                              in_ready,
  output logic                              out_valid,
  output logic                              out_too_few,
  output logic signed [tkms_pkg::SUM_W-1:0] out_sum,
  input  logic                              out_ready
);
  import tkms_pkg::*;

  logic signed [SUM_W-1:0] lvl_r [LEVELS+1][LANES];
  logic [LEVELS:0]         v_r;
  logic [LEVELS:0]         tf_r;
  logic [LEVELS+1:0]       can_load;

  assign can_load[LEVELS+1] = out_ready;

  for (genvar l = 0; l <= LEVELS; l++) begin : g_ctl
    assign can_load[l] = !v_r[l] || can_load[l+1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (can_load[0]) begin
        v_r[0] <= in_valid;
      end
      for (int l = 1; l <= LEVELS; l++) begin
        if (can_load[l]) begin
          v_r[l] <= v_r[l-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load[0]) begin
      tf_r[0] <= in_too_few;
      lvl_r[0] <= lane_val;
    end
  end

  for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
    always_ff @(posedge clk) begin
      if (can_load[l]) begin
        tf_r[l] <= tf_r[l-1];
      end
    end
    for (genvar j = 0; j < LANES; j++) begin : g_lane
      if (j < (LANES >> l)) begin : g_add
        always_ff @(posedge clk) begin
          if (can_load[l]) begin
            lvl_r[l][j] <= lvl_r[l-1][2*j] + lvl_r[l-1][2*j+1];
          end
        end
      end else begin : g_pad
        always_ff @(posedge clk) begin
          lvl_r[l][j] <= '0;
        end
      end
    end
  end

  assign in_ready    = can_load[0];
  assign out_valid   = v_r[LEVELS];
  assign out_too_few = tf_r[LEVELS];
  assign out_sum     = lvl_r[LEVELS][0];

endmodule

### sv/top_k_max_sum_core.sv
// Sum of the k largest elements of a sequence, one element per cycle.
// After its last element, the result of a run passes the pending flag, the snapshot level of
// the registered adder tree and then each adder level of that tree.
// Throughput: one element per cycle while the result side keeps up.
// Reset: k_r returns to 1, the store is empty and no result is pending.
`include "top_k_max_sum_core_defines.svh"
module top_k_max_sum_core #(
  parameter int K_MAX = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [tkms_pkg::K_W-1:0]  cfg_wr_data,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [31:0]               in_tdata,   // [31:0] value
  input  logic                      in_tlast,   // last
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [39:0]               out_tdata,  // [35:0] max_sum, [39:36] zero
  output logic [0:0]                out_tuser   // [0] too_few
);
  import tkms_pkg::*;

  localparam int CW     = $clog2(K_MAX + 1);
  localparam int EW     = (CW > K_W) ? CW : K_W;
  localparam int LEVELS = $clog2(K_MAX);
  localparam int LANES  = 1 << LEVELS;

  logic [K_W-1:0]          k_r;
  logic [CW-1:0]           count_r;
  logic [CW-1:0]           count_nxt;
  logic                    pend_r;
  logic                    pend_nxt;
  logic                    in_fire;
  logic                    snap_ready;
  logic [EW-1:0]           eff_k;
  logic                    too_few;
  logic signed [VAL_W-1:0] value;
  logic signed [SUM_W-1:0] tree_sum;
  logic                    tree_too_few;

  tkms_link_t              link [K_MAX+1];
  logic signed [VAL_W-1:0] entry [K_MAX];
  logic signed [SUM_W-1:0] lane_val [LANES];

  assign value     = in_tdata;
  assign in_tready = !pend_r || snap_ready;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r <= K_W'(1);
    end else if (cfg_wr_en) begin
      k_r <= cfg_wr_data;
    end
  end

  // A pending snapshot means the previous run ended: the next element starts empty.
  always_comb begin
    count_nxt = count_r;
    // Once the snapshot is taken the store is empty, even if no element arrives.
    if (pend_r && snap_ready) begin
      count_nxt = '0;
    end
    if (in_fire) begin
      if (pend_r) begin
        count_nxt = CW'(1);
      end else if (count_r != CW'(K_MAX)) begin
        count_nxt = count_r + CW'(1);
      end
    end
    pend_nxt = pend_r && !snap_ready;
    if (in_fire && in_tlast) begin
      pend_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign link[0].stays = 1'b1;
  assign link[0].entry = value;

  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    tkms_cell u_cell (
      .clk      (clk),
      .accept   (in_fire),
      .value    (value),
      .occupied ((CW'(i) < count_r) && !pend_r),
      .prev     (link[i]),
      .link     (link[i+1]),
      .entry    (entry[i])
    );
  end

  assign eff_k   = (EW'(k_r) > EW'(K_MAX)) ? EW'(K_MAX) : EW'(k_r);
  assign too_few = (eff_k == '0) || (EW'(count_r) < eff_k);

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    if (i < K_MAX) begin : g_used
      assign lane_val[i] = ((CW'(i) < count_r) && (EW'(i) < eff_k))
                           ? SUM_W'(entry[i]) : '0;
    end else begin : g_pad
      assign lane_val[i] = '0;
    end
  end

  tkms_sum_tree #(
    .LANES  (LANES),
    .LEVELS (LEVELS)
  ) u_tree (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pend_r),
    .in_too_few  (too_few),
    .lane_val    (lane_val),
    .in_ready    (snap_ready),
    .out_valid   (out_tvalid),
    .out_too_few (tree_too_few),
    .out_sum     (tree_sum),
    .out_ready   (out_tready)
  );

  assign out_tdata    = {4'b0000, (tree_too_few ? SUM_W'(0) : tree_sum)};
  assign out_tuser[0] = tree_too_few;

  `TKMS_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CW'(K_MAX))
  `TKMS_ASSERT_SAME(a_few_is_zero, out_tvalid && out_tuser[0], out_tdata[35:0] == 36'd0)
  `TKMS_ASSERT_NEXT(a_last_pends, in_tvalid && in_tready && in_tlast, pend_r)
  `TKMS_ASSERT_NEXT(a_new_run_one, in_tvalid && in_tready && pend_r, count_r == CW'(1))

endmodule

### tb/tb_top_k_max_sum_core.sv
// Self-checking testbench for top_k_max_sum_core: sequences of signed elements with random
// flow control on both streams, checked against a sorted-store predictor kept in the bench.
// Depends on tkms_pkg and the core RTL only.
module tb_top_k_max_sum_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tkms_pkg::*;

  localparam int DEPTH           = 16;
  localparam int DRAIN_CYCLES    = 12;
  localparam int PHASE_ITEMS     = 200;
  localparam int NUM_PHASES      = 8;

  typedef logic signed [VAL_W-1:0] elem_t;

  localparam elem_t VAL_MAX = 32'sh7FFF_FFFF;
  localparam elem_t VAL_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [SUM_W-1:0] max_sum;
    logic                    too_few;
  } sum_result_t;

  typedef enum int {MIX_FULL, MIX_CLOSE, MIX_EDGE, MIX_NEG} value_mix_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE} stall_mode_t;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic [K_W-1:0]   cfg_wr_data = '0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [31:0]      in_tdata    = '0;   // [31:0] value
  logic             in_tlast    = 1'b0; // last
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [39:0]      out_tdata;          // [35:0] max_sum, [39:36] zero
  logic [0:0]       out_tuser;          // [0] too_few

  // Bench copy of the block state.
  elem_t            ranked_vals [DEPTH];
  int unsigned      held_count  = 0;
  logic [K_W-1:0]   k_setting   = 5'd1;
  sum_result_t      expected_sums [$];
  int               errors      = 0;
  int               burst_left  = 0;

  stall_mode_t      rx_mode     = RX_OPEN;
  int               rx_left     = 0;
  logic [7:0]       rx_count    = '0;

  top_k_max_sum_core #(.K_MAX(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Inserts one element into the descending store and, on the last element of a
  // sequence, queues the sum of the k largest held entries.
  function automatic void rank_element(elem_t v, logic lst);
    int unsigned             pos;
    int unsigned             lim;
    int unsigned             kk;
    logic signed [SUM_W-1:0] acc;
    sum_result_t             res;
    pos = 0;
    while (pos < held_count && ranked_vals[pos] >= v) pos++;
    if (pos < DEPTH) begin
      lim = (held_count < DEPTH) ? held_count : DEPTH - 1;
      for (int i = lim; i > pos; i--) ranked_vals[i] = ranked_vals[i-1];
      ranked_vals[pos] = v;
      if (held_count < DEPTH) held_count++;
    end
    if (lst) begin
      kk = (k_setting > DEPTH) ? DEPTH : k_setting;
      acc = '0;
      for (int i = 0; i < kk && i < held_count; i++) acc += ranked_vals[i];
      res.too_few = (kk == 0) || (held_count < kk);
      res.max_sum = res.too_few ? '0 : acc;
      expected_sums.push_back(res);
      held_count = 0;
    end
  endfunction

  function automatic elem_t pick_value(value_mix_t mix);
    elem_t v;
    case (mix)
      MIX_FULL:  v = elem_t'($urandom);
      MIX_CLOSE: v = elem_t'($urandom_range(0, 8)) - 4;
      MIX_EDGE: begin
        if ($urandom_range(0, 1) == 1) v = VAL_MAX - elem_t'($urandom_range(0, 3));
        else v = VAL_MIN + elem_t'($urandom_range(0, 3));
      end
      default:   v = {1'b1, 31'($urandom)};
    endcase
    return v;
  endfunction

  // The sender works in bursts; a gap of random length opens when a burst runs out.
  task automatic send_elem(input elem_t v, input logic lst);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= v;
    in_tlast  <= lst;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    rank_element(v, lst);
    burst_left--;
  endtask

  // Holds the input back until every queued sum has arrived and the chain has settled.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_sums.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_k(input logic [K_W-1:0] kv);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= kv;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    k_setting    = kv;
  endtask

  task automatic send_run(input int len, input value_mix_t mix);
    for (int i = 0; i < len; i++) send_elem(pick_value(mix), i == len - 1);
  endtask

  task automatic test_reset_k();
    send_elem(VAL_MAX, 1'b1);
  endtask

  task automatic test_short_runs();
    wait_idle();
    write_k(5'd0);
    send_elem(VAL_MIN, 1'b1);
    wait_idle();
    write_k(5'd2);
    send_elem(VAL_MIN, 1'b1);
  endtask

  // A k above the store depth saturates; the smallest entry falls out when the store is full.
  task automatic test_full_store();
    wait_idle();
    write_k(5'd31);
    send_elem(VAL_MIN, 1'b0);
    for (int i = 0; i < DEPTH; i++) send_elem(VAL_MAX, i == DEPTH - 1);
  endtask

  task automatic test_k_midrun();
    wait_idle();
    write_k(5'd2);
    send_elem(-5, 1'b0);
    wait_idle();
    write_k(5'd1);
    send_elem(-5, 1'b1);
  endtask

  task automatic test_random_phases();
    logic [K_W-1:0] kv;
    int             sent;
    int             len;
    int             pick;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0:       kv = 5'd1;
        1:       kv = 5'd16;
        2:       kv = 5'd0;
        3:       kv = 5'd31;
        default: kv = K_W'($urandom_range(0, 31));
      endcase
      wait_idle();
      write_k(kv);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) len = $urandom_range(1, 20);
        else if (pick < 9) len = $urandom_range(16, 40);
        else len = 1;
        send_run(len, value_mix_t'($urandom_range(0, 3)));
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_k();
    test_short_runs();
    test_full_store();
    test_k_midrun();
    test_random_phases();
    wait_idle();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("FAILED: results differ");
    $finish;
  end

  // The receiver switches between stall patterns at random intervals.
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= stall_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(30, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_count <= rx_count + 1'b1;
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_COIN:     out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= (rx_count[2:0] < 3'd3);
      default:     out_tready <= (rx_count[3:0] == 4'd0);
    endcase
  end

  always @(posedge clk) begin
    sum_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_sums.size() == 0) begin
        $error("result with nothing expected: max_sum %0d too_few %0d",
               $signed(out_tdata[35:0]), out_tuser[0]);
        errors++;
      end else begin
        want = expected_sums.pop_front();
        if (out_tdata[35:0] !== want.max_sum) begin
          $error("max_sum: expected %0d, actual %0d", want.max_sum, $signed(out_tdata[35:0]));
          errors++;
        end
        if (out_tuser[0] !== want.too_few) begin
          $error("too_few: expected %0d, actual %0d", want.too_few, out_tuser[0]);
          errors++;
        end
        if (out_tdata[39:36] !== 4'd0) begin
          $error("tdata padding: expected 0, actual %0h", out_tdata[39:36]);
          errors++;
        end
      end
    end
  end

endmodule
